@@ rtl/core/etmm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package etmm_pkg;

    // CORDIC length, at most the atan table size
    localparam int unsigned CORDIC_STAGES = 16;
    localparam int unsigned ATAN_ENTRIES  = 24;

    // Q.30 values carry up to about 2.0 plus CORDIC growth, so 34 bits hold them
    localparam int unsigned QW = 34;
    // folding works on the widened angle, Q4.12 << 18 needs 34 bits, 36 with margin
    localparam int unsigned ZW = 36;

    localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [QW-1:0] Q30_GAIN    = 34'sd652032874;
    localparam logic signed [67:0]   Q30_HALF    = 68'sd536870912;

    typedef logic signed [QW-1:0] t_q30;

    // arctangent of 2^-i in Q.30, truncated
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 36'sh03243F6A8;
            5'd1:    v = 36'sh01DAC6705;
            5'd2:    v = 36'sh00FADBAFC;
            5'd3:    v = 36'sh007F56EA6;
            5'd4:    v = 36'sh003FEAB76;
            5'd5:    v = 36'sh001FFD55B;
            5'd6:    v = 36'sh000FFFAAA;
            5'd7:    v = 36'sh0007FFF55;
            5'd8:    v = 36'sh0003FFFEA;
            5'd9:    v = 36'sh0001FFFFD;
            5'd10:   v = 36'sh0000FFFFF;
            5'd11:   v = 36'sh00007FFFF;
            5'd12:   v = 36'sh00003FFFF;
            5'd13:   v = 36'sh00001FFFF;
            5'd14:   v = 36'sh00000FFFF;
            5'd15:   v = 36'sh000007FFF;
            5'd16:   v = 36'sh000003FFF;
            5'd17:   v = 36'sh000001FFF;
            5'd18:   v = 36'sh000000FFF;
            5'd19:   v = 36'sh0000007FF;
            5'd20:   v = 36'sh0000003FF;
            5'd21:   v = 36'sh0000001FF;
            5'd22:   v = 36'sh0000000FF;
            5'd23:   v = 36'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // product of two Q.30 values, rounded to Q.30
    function automatic t_q30 mul30(input t_q30 a, input t_q30 b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + Q30_HALF;
        return t_q30'(p >>> 30);
    endfunction

    // input item
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] t_x;
        logic signed [31:0] t_y;
        logic signed [31:0] t_z;
    } t_out_item;

    // sine and cosine of one angle
    typedef struct packed {
        t_q30 s;
        t_q30 c;
    } t_sc;

    // data carried beside the trig pipeline
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } t_side;

endpackage

`default_nettype wire

@@ rtl/core/etmm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface etmm_in_if;
    logic               valid;
    logic               ready;
    etmm_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface etmm_out_if;
    logic                valid;
    logic                ready;
    etmm_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/etmm_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined CORDIC: one fold stage, then one register stage per iteration.
module etmm_cordic (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [15:0]  i_angle,
    output etmm_pkg::t_sc            o_sc
);
    localparam int unsigned NS = (etmm_pkg::CORDIC_STAGES < etmm_pkg::ATAN_ENTRIES) ?
                                 etmm_pkg::CORDIC_STAGES : etmm_pkg::ATAN_ENTRIES;
    localparam int unsigned ZW = etmm_pkg::ZW;
    localparam int unsigned QW = etmm_pkg::QW;

    logic signed [ZW-1:0] n_z0;
    logic                 n_neg0;
    logic signed [ZW-1:0] r_z  [0:NS];
    logic signed [QW-1:0] r_x  [0:NS];
    logic signed [QW-1:0] r_y  [0:NS];
    logic                 r_neg[0:NS];

    // fold the angle into -pi/2..pi/2
    always_comb begin
        logic signed [ZW-1:0] z;
        z = ZW'(i_angle) <<< 18;
        n_neg0 = 1'b0;
        if (z > etmm_pkg::Q30_PI) begin
            z = z - etmm_pkg::Q30_TWO_PI;
        end else if (z < -etmm_pkg::Q30_PI) begin
            z = z + etmm_pkg::Q30_TWO_PI;
        end
        if (z > etmm_pkg::Q30_HALF_PI) begin
            z = z - etmm_pkg::Q30_PI;
            n_neg0 = 1'b1;
        end else if (z < -etmm_pkg::Q30_HALF_PI) begin
            z = z + etmm_pkg::Q30_PI;
            n_neg0 = 1'b1;
        end
        n_z0 = z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]   <= n_z0;
            r_x[0]   <= etmm_pkg::Q30_GAIN;
            r_y[0]   <= '0;
            r_neg[0] <= n_neg0;
        end
    end

    // one micro-rotation per stage
    for (genvar g = 0; g < NS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - etmm_pkg::atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + etmm_pkg::atan_q30(5'(g));
                end
            end
        end
    end

    assign o_sc.c = r_neg[NS] ? -r_x[NS] : r_x[NS];
    assign o_sc.s = r_neg[NS] ? -r_y[NS] : r_y[NS];

endmodule

`default_nettype wire

@@ rtl/core/etmm_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Rotation products, sums, then scaling with saturation; four register stages.
module etmm_matrix (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire etmm_pkg::t_sc       i_sc1,
    input  wire etmm_pkg::t_sc       i_sc2,
    input  wire etmm_pkg::t_sc       i_sc3,
    input  wire etmm_pkg::t_side     i_side,
    output etmm_pkg::t_out_item      o_item
);
    typedef etmm_pkg::t_q30 t_q;

    // stage A: single products
    t_q r_c1c3, r_s1s2, r_c1s2, r_c3s1, r_c1s3, r_c2s3, r_c2c3, r_s1s3, r_c2s1, r_c1c2;
    t_q r_s2a, r_s3a;
    etmm_pkg::t_side r_sa;
    // stage B: second products and sums
    t_q r_e [0:8];
    etmm_pkg::t_side r_sb;
    // stage C: scaled entries
    logic signed [63:0] r_p [0:8];
    etmm_pkg::t_side r_sc;
    t_q n_e [0:8];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1c3 <= etmm_pkg::mul30(i_sc1.c, i_sc3.c);
            r_s1s2 <= etmm_pkg::mul30(i_sc1.s, i_sc2.s);
            r_c1s2 <= etmm_pkg::mul30(i_sc1.c, i_sc2.s);
            r_c3s1 <= etmm_pkg::mul30(i_sc3.c, i_sc1.s);
            r_c1s3 <= etmm_pkg::mul30(i_sc1.c, i_sc3.s);
            r_c2s3 <= etmm_pkg::mul30(i_sc2.c, i_sc3.s);
            r_c2c3 <= etmm_pkg::mul30(i_sc2.c, i_sc3.c);
            r_s1s3 <= etmm_pkg::mul30(i_sc1.s, i_sc3.s);
            r_c2s1 <= etmm_pkg::mul30(i_sc2.c, i_sc1.s);
            r_c1c2 <= etmm_pkg::mul30(i_sc1.c, i_sc2.c);
            r_s2a  <= i_sc2.s;
            r_s3a  <= i_sc3.s;
            r_sa   <= i_side;
        end
    end

    // combine into the nine rotation entries
    always_comb begin
        n_e[0] = r_c1c3 + etmm_pkg::mul30(r_s1s2, r_s3a);
        n_e[1] = r_c2s3;
        n_e[2] = etmm_pkg::mul30(r_c1s2, r_s3a) - r_c3s1;
        n_e[3] = etmm_pkg::mul30(r_c3s1, r_s2a) - r_c1s3;
        n_e[4] = r_c2c3;
        n_e[5] = etmm_pkg::mul30(r_c1c3, r_s2a) + r_s1s3;
        n_e[6] = r_c2s1;
        n_e[7] = -r_s2a;
        n_e[8] = r_c1c2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_e[k] <= n_e[k];
            end
            r_sb <= r_sa;
        end
    end

    // scale each row, round to Q16.16 before saturation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                logic signed [67:0] p;
                logic signed [31:0] s;
                s = (k < 3) ? r_sb.scale_x : ((k < 6) ? r_sb.scale_y : r_sb.scale_z);
                p = 68'(s) * 68'(r_e[k]) + etmm_pkg::Q30_HALF;
                r_p[k] <= 64'(p >>> 30);
            end
            r_sc <= r_sb;
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_item.m00 <= sat32(r_p[0]);
            o_item.m01 <= sat32(r_p[1]);
            o_item.m02 <= sat32(r_p[2]);
            o_item.m10 <= sat32(r_p[3]);
            o_item.m11 <= sat32(r_p[4]);
            o_item.m12 <= sat32(r_p[5]);
            o_item.m20 <= sat32(r_p[6]);
            o_item.m21 <= sat32(r_p[7]);
            o_item.m22 <= sat32(r_p[8]);
            o_item.t_x <= r_sc.pos_x;
            o_item.t_y <= r_sc.pos_y;
            o_item.t_z <= r_sc.pos_z;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/euler_trs_model_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Model matrix generator: position, Y-X-Z Euler angles and axis scale in,
// the upper three rows of the affine model matrix out.
// Input channel carries one item of nine fields; output channel carries nine
// saturated Q16.16 rotation-scale entries and the unaltered translation.
// Both channels use valid/ready; an item moves when both are high.
// The pipeline is one fold stage, one stage per CORDIC iteration, and four
// product/scale stages, so its depth is set by the CORDIC iteration count.
// Throughput is one item per cycle while no receiver stall holds the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and the input stops taking items; nothing is lost or repeated.
// Reset clears only the valid bits, so no result appears until an item
// has travelled the full pipeline.
module euler_trs_model_matrix (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    etmm_in_if.sink     i_in,
    etmm_out_if.source  o_out
);
    localparam int unsigned NS = (etmm_pkg::CORDIC_STAGES < etmm_pkg::ATAN_ENTRIES) ?
                                 etmm_pkg::CORDIC_STAGES : etmm_pkg::ATAN_ENTRIES;
    localparam int unsigned DEPTH = NS + 5;

    logic [DEPTH-1:0] r_vld;
    logic             w_en;
    etmm_pkg::t_sc    w_sc1, w_sc2, w_sc3;
    etmm_pkg::t_side  r_side [0:NS];
    etmm_pkg::t_side  n_side;

    // advance whenever the last stage is empty or taken
    assign w_en       = !r_vld[DEPTH-1] || o_out.ready;
    assign i_in.ready = w_en;
    assign o_out.valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
        end
    end

    assign n_side.pos_x   = i_in.data.pos_x;
    assign n_side.pos_y   = i_in.data.pos_y;
    assign n_side.pos_z   = i_in.data.pos_z;
    assign n_side.scale_x = i_in.data.scale_x;
    assign n_side.scale_y = i_in.data.scale_y;
    assign n_side.scale_z = i_in.data.scale_z;

    // delay position and scale alongside the CORDIC
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k <= NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    etmm_cordic u_cordic_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in.data.angle_y),
        .o_sc    (w_sc1)
    );

    etmm_cordic u_cordic_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in.data.angle_x),
        .o_sc    (w_sc2)
    );

    etmm_cordic u_cordic_z (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in.data.angle_z),
        .o_sc    (w_sc3)
    );

    etmm_matrix u_matrix (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sc1  (w_sc1),
        .i_sc2  (w_sc2),
        .i_sc3  (w_sc3),
        .i_side (r_side[NS]),
        .o_item (o_out.data)
    );

endmodule

`default_nettype wire

@@ tb/tb_euler_trs_model_matrix.sv @@
`timescale 1ns / 1ps

module tb_euler_trs_model_matrix;

    typedef logic signed [63:0] t_q64;

    // Tait-Bryan matrix predictor and the queue of matrices still owed by the block
    class matrix_board;
        etmm_pkg::t_out_item owed[$];
        int        n_bad;
        int        n_seen;

        function t_q64 fshift(t_q64 v, int s);
            return v >>> s;
        endfunction

        function t_q64 qmul(t_q64 a, t_q64 b);
            return fshift(a * b + 64'sd536870912, 30);
        endfunction

        function void trig(logic signed [15:0] ang, output t_q64 s, output t_q64 c);
            t_q64 z, x, y, dx, dy;
            bit   flip;
            z = t_q64'(ang) * 262144;
            x = 64'sd652032874;
            y = 0;
            flip = 0;
            if (z > 64'sd3373259426) z = z - 64'sd6746518852;
            else if (z < -64'sd3373259426) z = z + 64'sd6746518852;
            if (z > 64'sd1686629713) begin
                z = z - 64'sd3373259426;
                flip = 1;
            end else if (z < -64'sd1686629713) begin
                z = z + 64'sd3373259426;
                flip = 1;
            end
            for (int i = 0; i < etmm_pkg::CORDIC_STAGES && i < etmm_pkg::ATAN_ENTRIES;
                 i++) begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - t_q64'(etmm_pkg::atan_q30(5'(i)));
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + t_q64'(etmm_pkg::atan_q30(5'(i)));
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = x;
            s = y;
        endfunction

        function logic signed [31:0] scaled(logic signed [31:0] k, t_q64 e);
            t_q64 r;
            r = fshift(t_q64'(k) * e + 64'sd536870912, 30);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note_item(etmm_pkg::t_in_item it);
            t_q64 s1, c1, s2, c2, s3, c3;
            etmm_pkg::t_out_item m;
            trig(it.angle_y, s1, c1);
            trig(it.angle_x, s2, c2);
            trig(it.angle_z, s3, c3);
            m.m00 = scaled(it.scale_x, qmul(c1, c3) + qmul(qmul(s1, s2), s3));
            m.m01 = scaled(it.scale_x, qmul(c2, s3));
            m.m02 = scaled(it.scale_x, qmul(qmul(c1, s2), s3) - qmul(c3, s1));
            m.m10 = scaled(it.scale_y, qmul(qmul(c3, s1), s2) - qmul(c1, s3));
            m.m11 = scaled(it.scale_y, qmul(c2, c3));
            m.m12 = scaled(it.scale_y, qmul(qmul(c1, c3), s2) + qmul(s1, s3));
            m.m20 = scaled(it.scale_z, qmul(c2, s1));
            m.m21 = scaled(it.scale_z, -s2);
            m.m22 = scaled(it.scale_z, qmul(c1, c2));
            m.t_x = it.pos_x;
            m.t_y = it.pos_y;
            m.t_z = it.pos_z;
            owed.push_back(m);
        endfunction

        function void fail(string f, logic [31:0] e, logic [31:0] a);
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch on matrix %0d field %s: expected %h, got %h",
                         n_seen, f, e, a);
        endfunction

        function void check_matrix(etmm_pkg::t_out_item got);
            etmm_pkg::t_out_item e;
            if (owed.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected matrix %h", got);
                return;
            end
            e = owed.pop_front();
            if (got.m00 !== e.m00) fail("m00", e.m00, got.m00);
            if (got.m01 !== e.m01) fail("m01", e.m01, got.m01);
            if (got.m02 !== e.m02) fail("m02", e.m02, got.m02);
            if (got.m10 !== e.m10) fail("m10", e.m10, got.m10);
            if (got.m11 !== e.m11) fail("m11", e.m11, got.m11);
            if (got.m12 !== e.m12) fail("m12", e.m12, got.m12);
            if (got.m20 !== e.m20) fail("m20", e.m20, got.m20);
            if (got.m21 !== e.m21) fail("m21", e.m21, got.m21);
            if (got.m22 !== e.m22) fail("m22", e.m22, got.m22);
            if (got.t_x !== e.t_x) fail("t_x", e.t_x, got.t_x);
            if (got.t_y !== e.t_y) fail("t_y", e.t_y, got.t_y);
            if (got.t_z !== e.t_z) fail("t_z", e.t_z, got.t_z);
            n_seen++;
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    etmm_in_if  in_ch ();
    etmm_out_if out_ch ();
    matrix_board board = new();

    bit calm;       // no idling in the closing stretch
    bit hold_off;   // long receiver stall in progress
    int n_sent;

    euler_trs_model_matrix dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    initial begin
        in_ch.valid  = 0;
        in_ch.data   = '0;
        out_ch.ready = 0;
    end

    // note accepted items, check accepted matrices
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) board.note_item(in_ch.data);
        if (i_rst_n && out_ch.valid && out_ch.ready) board.check_matrix(out_ch.data);
    end

    // receiver: random stall bursts, one long hold-off
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 0;
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 16);
                out_ch.ready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [31:0] rand32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic etmm_pkg::t_in_item rand_item();
        etmm_pkg::t_in_item it;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        it.angle_x = $urandom;
        it.angle_y = $urandom;
        it.angle_z = $urandom;
        // mostly angles in one turn, some over the whole code range
        if ($urandom_range(0, 3) != 0) begin
            it.angle_x = 16'($signed($urandom_range(0, 25736)) - 12868);
            it.angle_y = 16'($signed($urandom_range(0, 25736)) - 12868);
            it.angle_z = 16'($signed($urandom_range(0, 25736)) - 12868);
        end
        it.scale_x = rand32();
        it.scale_y = rand32();
        it.scale_z = rand32();
        return it;
    endfunction

    // offer one item and hold it until taken
    task automatic send_item(etmm_pkg::t_in_item it);
        in_ch.valid <= 1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    initial begin
        etmm_pkg::t_in_item it;
        logic signed [15:0] angs[10];
        angs = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sd12868,
            -16'sd12868, 16'sd6434, -16'sd6434, 16'sd6435, 16'sd12869, 16'sh0001};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: angle extremes and fold edges, unit and extreme scales
        for (int i = 0; i < 10; i++) begin
            it = '0;
            it.angle_x = angs[i];
            it.angle_y = angs[(i + 3) % 10];
            it.angle_z = angs[(i + 7) % 10];
            it.scale_x = 32'sh0001_0000;
            it.scale_y = 32'sh0001_0000;
            it.scale_z = 32'sh0001_0000;
            it.pos_x = 32'h7FFF_FFFF;
            it.pos_y = 32'h8000_0000;
            it.pos_z = 32'hFFFF_FFFF;
            send_item(it);
        end
        for (int i = 0; i < 8; i++) begin
            it = '0;
            it.angle_x = angs[i];
            it.angle_y = angs[i + 1];
            it.angle_z = angs[i + 2];
            it.scale_x = i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            it.scale_y = i[1] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            it.scale_z = i[2] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            it.pos_x = $urandom;
            send_item(it);
        end

        // random, with a long receiver hold-off early on
        for (int i = 0; i < 1600; i++) begin
            if (i == 100) hold_off = 1;
            if (i == 1350) calm = 1;
            sender_gap();
            send_item(rand_item());
        end
        in_ch.valid <= 0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("sent %0d items, checked %0d matrices incl. folded angles and saturation",
                 n_sent, board.n_seen);
        if (board.n_bad == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout waiting for matrices");
        $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ euler_trs_model_matrix.f @@
rtl/core/etmm_pkg.sv
rtl/core/etmm_if.sv
rtl/core/etmm_cordic.sv
rtl/core/etmm_matrix.sv
rtl/core/euler_trs_model_matrix.sv
tb/tb_euler_trs_model_matrix.sv
